### hdl/utf8md_pkg.sv
package utf8md_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned COUNT_W = 2;

   // Lead and continuation byte patterns.
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'b1110_0000;
   localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'b1100_0000;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'b1111_0000;
   localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'b1110_0000;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'b1111_1000;
   localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'b1111_0000;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'b1100_0000;
   localparam logic [BYTE_W-1:0] CONT_PAT   = 8'b1000_0000;

   localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_ONE  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_TWO  = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_THREE = 2'd3;

   typedef enum logic [1:0] {
      KIND_MORE   = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [CP_W-1:0]    partial;
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic [CP_W-1:0]    code_point;
      logic [COUNT_W-1:0] byte_count;
   } result_type;

endpackage

### hdl/utf8_multibyte_decoder_top.sv
// An accepted byte is held in the input register, and its result moves on into
// the result register once that register is free to take it.
// Throughput: one byte per cycle, sustained, while the result side keeps up. A
// held result stalls the input side once both registers are full.
// Reset: synchronous and active high; it empties both registers and returns
// the decoder to idle, expecting a lead byte, with no code point gathered.
module utf8_multibyte_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [utf8md_pkg::BYTE_W-1:0]     req_in_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output utf8md_pkg::kind_type              rsp_result_kind,
   output logic [utf8md_pkg::CP_W-1:0]       rsp_code_point,
   output logic [utf8md_pkg::COUNT_W-1:0]    rsp_byte_count
);
   import utf8md_pkg::*;

   // Input register: holds one accepted byte until the decode step consumes it.
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Decoder state: the number of continuation bytes still expected and the
   // code point bits gathered so far. It advances only when a byte moves from
   // the input register into the result register, so that each byte is seen
   // exactly once however the two sides stall.
   state_type state_ff;
   state_type state_in;

   // Result register.
   logic       out_valid_ff;
   result_type out_ff;
   result_type out_in;

   logic advance;
   logic out_free;

   utf8md_step u_step (
      .state_cur (state_ff),
      .in_byte   (in_byte_ff),
      .state_nxt (state_in),
      .result    (out_in)
   );

   // The result register can take a new result when it is empty or when its
   // current result is being transferred in this cycle.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   // A new byte is taken whenever the input register is empty or is being
   // drained, so back-to-back transfers run at one per cycle while the result side keeps up.
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_ff.kind;
   assign rsp_code_point  = out_ff.code_point;
   assign rsp_byte_count  = out_ff.byte_count;

endmodule

### hdl/utf8md_step.sv
module utf8md_step (
   input  utf8md_pkg::state_type         state_cur,
   input  logic [utf8md_pkg::BYTE_W-1:0] in_byte,
   output utf8md_pkg::state_type         state_nxt,
   output utf8md_pkg::result_type        result
);
   import utf8md_pkg::*;

   logic [CP_W-1:0]    shifted;
   logic [COUNT_W-1:0] count;

   // Append the six payload bits of a continuation byte.
   assign shifted = {state_cur.partial[CP_W-7:0], in_byte[5:0]};

   always_comb begin
      priority if (|shifted[20:16]) begin
         count = 2'd3;
      end else if (|shifted[15:8]) begin
         count = 2'd2;
      end else if (|shifted[7:0]) begin
         count = 2'd1;
      end else begin
         count = 2'd0;
      end
   end

   always_comb begin
      state_nxt         = '0;
      result.kind       = KIND_MORE;
      result.code_point = '0;
      result.byte_count = '0;
      if (state_cur.phase == PHASE_IDLE) begin
         priority if ((in_byte & LEAD2_MASK) == LEAD2_PAT) begin
            state_nxt.phase   = PHASE_ONE;
            state_nxt.partial = CP_W'(in_byte[4:0]);
         end else if ((in_byte & LEAD3_MASK) == LEAD3_PAT) begin
            state_nxt.phase   = PHASE_TWO;
            state_nxt.partial = CP_W'(in_byte[3:0]);
         end else if ((in_byte & LEAD4_MASK) == LEAD4_PAT) begin
            state_nxt.phase   = PHASE_THREE;
            state_nxt.partial = CP_W'(in_byte[2:0]);
         end else begin
            result.kind = KIND_REJECT;
         end
      end else if ((in_byte & CONT_MASK) == CONT_PAT) begin
         if (state_cur.phase == PHASE_ONE) begin
            result.kind       = KIND_DONE;
            result.code_point = shifted;
            result.byte_count = count;
         end else begin
            state_nxt.phase   = state_cur.phase - PHASE_ONE;
            state_nxt.partial = shifted;
         end
      end else begin
         result.kind = KIND_REJECT;
      end
   end

endmodule

### tb/tb_utf8_multibyte_decoder_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the UTF-8 multibyte decoder.
//
// Bytes are queued up front by the stimulus process and fed through the
// request channel by a clocked driver. Every byte that the decoder accepts
// is run through a behavioural decoder in this file, and the result that it
// gives is queued. A clocked monitor on the result channel takes each
// result transfer and compares it, field by field, with the oldest queued
// result.
module tb_utf8_multibyte_decoder_top;

   import utf8md_pkg::*;

   localparam int ITEM_TARGET = 1800;
   localparam int IDLE_PCT    = 6;
   localparam int QUIET_FROM  = 700;
   localparam int QUIET_TO    = 1300;
   localparam int STALL_LIMIT = 200;
   localparam int DRAIN_TICKS = 8;
   localparam int REPORT_MAX  = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_in_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   kind_type            rsp_result_kind;
   logic [CP_W-1:0]     rsp_code_point;
   logic [COUNT_W-1:0]  rsp_byte_count;

   // Bytes still to be offered, and results still to be seen.
   logic [BYTE_W-1:0]   pending_bytes[$];
   result_type          expected_results[$];

   // State of the behavioural decoder.
   logic [PHASE_W-1:0]  dec_phase;
   logic [CP_W-1:0]     dec_partial;

   logic                req_taken = 1'b0;
   int                  cycle_count = 0;
   int                  stall_cycles = 0;
   int                  error_count = 0;
   int                  bytes_sent = 0;
   int                  chars_seen = 0;
   int                  rejects_seen = 0;
   int                  partials_seen = 0;
   int                  seq_count[2:4];

   utf8_multibyte_decoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_code_point  (rsp_code_point),
      .rsp_byte_count  (rsp_byte_count)
   );

   always #6 clock = ~clock;

   // Behavioural decoder: takes one byte, advances its own state and
   // returns the single result that the byte causes. A byte that breaks the
   // pattern mid-sequence is rejected outright and is not looked at again as
   // the lead byte of a new sequence.
   function automatic result_type decode_byte(input logic [BYTE_W-1:0] b);
      result_type res;
      res.kind       = KIND_MORE;
      res.code_point = '0;
      res.byte_count = '0;
      if (dec_phase == PHASE_IDLE) begin
         casez (b)
            8'b110?????: begin
               dec_partial = {16'd0, b[4:0]};
               dec_phase   = PHASE_ONE;
            end
            8'b1110????: begin
               dec_partial = {17'd0, b[3:0]};
               dec_phase   = PHASE_TWO;
            end
            8'b11110???: begin
               dec_partial = {18'd0, b[2:0]};
               dec_phase   = PHASE_THREE;
            end
            default: begin
               // ASCII, a stray continuation byte or 0xF8 and above.
               res.kind    = KIND_REJECT;
               dec_partial = '0;
            end
         endcase
      end else if (b[7:6] == 2'b10) begin
         dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
         dec_phase   = dec_phase - 1'b1;
         if (dec_phase == PHASE_IDLE) begin
            res.kind       = KIND_DONE;
            res.code_point = dec_partial;
            // Significant big-endian bytes; a zero code point fills none.
            if (dec_partial > 21'h00FFFF)
               res.byte_count = 2'd3;
            else if (dec_partial > 21'h0000FF)
               res.byte_count = 2'd2;
            else if (dec_partial != '0)
               res.byte_count = 2'd1;
            dec_partial = '0;
         end
      end else begin
         res.kind    = KIND_REJECT;
         dec_phase   = PHASE_IDLE;
         dec_partial = '0;
      end
      return res;
   endfunction

   function automatic logic [BYTE_W-1:0] lead_byte(input int len);
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(255));
      case (len)
         2:       b[7:5] = 3'b110;
         3:       b[7:4] = 4'b1110;
         default: b[7:3] = 5'b11110;
      endcase
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] cont_byte();
      return {2'b10, 6'($urandom_range(63))};
   endfunction

   // Idling is switched off for a long window in the middle of the run so
   // that a stretch of back-to-back transfers is seen on both channels.
   function automatic logic quiet_window();
      return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
   endfunction

   // Request side at the rising edge: note whether a byte was taken and, if
   // so, predict what it causes. The driver reads the flag at the falling edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (reset) begin
         dec_phase   = PHASE_IDLE;
         dec_partial = '0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (req_valid && req_ready) begin
            expected_results.push_back(decode_byte(req_in_byte));
            bytes_sent <= bytes_sent + 1;
         end
      end
   end

   // Driver. A new byte, or an idle cycle, is chosen only once the current
   // byte has been transferred, so valid and the byte hold steady until then.
   always @(negedge clock) begin
      logic              next_valid;
      logic [BYTE_W-1:0] next_byte;
      next_valid = req_valid;
      next_byte  = req_in_byte;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         if (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
            next_valid = 1'b0;
         end else if (pending_bytes.size() != 0) begin
            next_valid = 1'b1;
            next_byte  = pending_bytes.pop_front();
         end else begin
            next_valid = 1'b0;
         end
      end
      req_valid   <= next_valid;
      req_in_byte <= next_byte;
      // The result side holds off at random in the same proportion.
      rsp_ready <= !reset && (quiet_window() || $urandom_range(99) >= IDLE_PCT);
   end

   // Monitor: each result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_result_kind)
            KIND_DONE:   chars_seen    <= chars_seen + 1;
            KIND_REJECT: rejects_seen  <= rejects_seen + 1;
            default:     partials_seen <= partials_seen + 1;
         endcase
         if (expected_results.size() == 0) begin
            error_count <= error_count + 1;
            if (error_count < REPORT_MAX)
               $display("%0t: result with nothing expected: kind %0d cp %06h count %0d",
                        $realtime, rsp_result_kind, rsp_code_point, rsp_byte_count);
         end else begin
            want = expected_results.pop_front();
            if (rsp_result_kind !== want.kind || rsp_code_point !== want.code_point ||
                rsp_byte_count !== want.byte_count) begin
               error_count <= error_count + 1;
               if (error_count < REPORT_MAX) begin
                  $display("%0t: mismatch: expected kind %0d cp %06h count %0d",
                           $realtime, want.kind, want.code_point, want.byte_count);
                  $display("%0t:           got kind %0d cp %06h count %0d",
                           $realtime, rsp_result_kind, rsp_code_point, rsp_byte_count);
               end
            end
         end
      end
   end

   // Watchdog: a run of cycles with no transfer on either channel means the
   // decoder has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      pending_bytes.push_back(b);
   endtask

   initial begin
      int pick;
      int len;
      int conts;
      logic [BYTE_W-1:0] bad;

      seq_count = '{0, 0, 0};

      // Directed part. Bytes that are rejected while idle: ASCII at both
      // ends of its range, a stray continuation byte, and the two ends of
      // the range that can never lead a sequence.
      push_byte(8'h00);
      push_byte(8'h7F);
      push_byte(8'h80);
      push_byte(8'hF8);
      push_byte(8'hFF);
      // Overlong form of zero: complete, with no significant bytes.
      push_byte(8'hC0); push_byte(8'h80);
      // Two-byte character filling one byte.
      push_byte(8'hC2); push_byte(8'hA9);
      // Largest three-byte character, and the smallest four-byte one.
      push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBF);
      push_byte(8'hF0); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80);
      // Every payload bit set: the top of the 21-bit range.
      push_byte(8'hF7); push_byte(8'hBF); push_byte(8'hBF); push_byte(8'hBF);
      // A lead byte in the middle of a sequence is rejected and not taken
      // as a new lead, so the continuation after it is rejected as well.
      push_byte(8'hE2); push_byte(8'hC3); push_byte(8'hA9);
      // Plain ASCII breaking a four-byte sequence.
      push_byte(8'hF4); push_byte(8'h41);

      // Random part: mostly well-formed sequences with random payload, the
      // rest single random bytes and sequences cut short by a bad byte.
      while (pending_bytes.size() < ITEM_TARGET) begin
         pick = $urandom_range(99);
         len  = $urandom_range(4, 2);
         if (pick < 80) begin
            push_byte(lead_byte(len));
            repeat (len - 1) push_byte(cont_byte());
            seq_count[len]++;
         end else if (pick < 90) begin
            push_byte(BYTE_W'($urandom_range(255)));
         end else begin
            conts = $urandom_range(len - 2, 0);
            bad   = BYTE_W'($urandom_range(255));
            if (bad[7:6] == 2'b10)
               bad[6] = 1'b1;
            push_byte(lead_byte(len));
            repeat (conts) push_byte(cont_byte());
            push_byte(bad);
         end
      end

      // Reset is held high from the start and released at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every byte to be transferred and every result to arrive,
      // then keep the clock running so that any stray result can still show.
      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);

      $display("Fed %0d bytes, including %0d/%0d/%0d well-formed 2/3/4-byte sequences.",
               bytes_sent, seq_count[2], seq_count[3], seq_count[4]);
      $display("Saw %0d characters, %0d rejections, %0d partial results; %0d errors.",
               chars_seen, rejects_seen, partials_seen, error_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
hdl/utf8md_pkg.sv
hdl/utf8md_step.sv
hdl/utf8_multibyte_decoder_top.sv
tb/tb_utf8_multibyte_decoder_top.sv
